>>> hw/rtl/lsc_pkg.sv
// Shared types and codes for the line sorter.
package lsc_pkg;

    localparam int MAX_LINES = 32;
    localparam int MAX_CHARS = 128;
    localparam int LINE_W    = $clog2(MAX_LINES);
    localparam int POS_W     = $clog2(MAX_CHARS);
    localparam int TEXT_AW   = LINE_W + POS_W;

    // input opcodes
    localparam logic [1:0] OPC_CHAR = 2'd0;
    localparam logic [1:0] OPC_EOL  = 2'd1;
    localparam logic [1:0] OPC_EOS  = 2'd2;

    // result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_MANY  = 2'd1;
    localparam logic [1:0] STS_NONE  = 2'd2;
    localparam logic [1:0] STS_TRUNC = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_REVERSE = 2'd0;
    localparam logic [1:0] CFG_FOLD    = 2'd1;
    localparam logic [1:0] CFG_DIR     = 2'd2;

    // datapath operations issued by the controller
    localparam logic [4:0] OP_NONE    = 5'd0;
    localparam logic [4:0] OP_LOAD    = 5'd1;
    localparam logic [4:0] OP_SINGLE  = 5'd2;
    localparam logic [4:0] OP_INIT    = 5'd3;
    localparam logic [4:0] OP_PUSH0   = 5'd4;
    localparam logic [4:0] OP_POP_RD  = 5'd5;
    localparam logic [4:0] OP_RANGE   = 5'd6;
    localparam logic [4:0] OP_SW_A    = 5'd7;
    localparam logic [4:0] OP_SW_B    = 5'd8;
    localparam logic [4:0] OP_LOOP_RD = 5'd9;
    localparam logic [4:0] OP_LD_I    = 5'd10;
    localparam logic [4:0] OP_C_RD    = 5'd11;
    localparam logic [4:0] OP_C_STEP  = 5'd12;
    localparam logic [4:0] OP_SWP_RD  = 5'd13;
    localparam logic [4:0] OP_SWP_W1  = 5'd14;
    localparam logic [4:0] OP_SWP_W2  = 5'd15;
    localparam logic [4:0] OP_FIN_RD  = 5'd16;
    localparam logic [4:0] OP_FIN_W1  = 5'd17;
    localparam logic [4:0] OP_FIN_W2  = 5'd18;
    localparam logic [4:0] OP_PUSH_HI = 5'd19;
    localparam logic [4:0] OP_PUSH_LO = 5'd20;
    localparam logic [4:0] OP_KCLR    = 5'd21;
    localparam logic [4:0] OP_EM_RD   = 5'd22;
    localparam logic [4:0] OP_EM_OUT  = 5'd23;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] ch;
    } in_t;

    typedef struct packed {
        logic [5:0] line_index;
        logic       last;
        logic [1:0] status;
    } out_t;

    typedef struct packed {
        logic [4:0] op;
    } cmd_t;

    typedef struct packed {
        logic eos;          // pending input is end of set
        logic many;         // too many lines in this run
        logic none;         // no lines in this run
        logic n_lt2;        // fewer than two lines
        logic k_done;       // init counter reached line count
        logic sp_zero;      // range stack empty
        logic range_empty;  // left >= right
        logic loop_done;    // partition scan finished
        logic cmp_skip;     // directory mode skipped a character
        logic cmp_done;     // comparison decided
        logic cmp_lt;       // scanned line sorts before pivot
        logic em_last;      // emitting final rank
        logic out_free;     // output register can take a result
    } stat_t;

endpackage

>>> hw/rtl/lsc_ctrl.sv
// Sequencer for loading, quicksort partitioning and result emission.
module lsc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lsc_pkg::stat_t st,
    output lsc_pkg::cmd_t  cmd
);
    import lsc_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_START  = 5'd1;
    localparam logic [4:0] ST_INIT   = 5'd2;
    localparam logic [4:0] ST_POP    = 5'd3;
    localparam logic [4:0] ST_RANGE  = 5'd4;
    localparam logic [4:0] ST_SWA    = 5'd5;
    localparam logic [4:0] ST_SWB    = 5'd6;
    localparam logic [4:0] ST_LOOP   = 5'd7;
    localparam logic [4:0] ST_LDI    = 5'd8;
    localparam logic [4:0] ST_CRD    = 5'd9;
    localparam logic [4:0] ST_CEV    = 5'd10;
    localparam logic [4:0] ST_SWP    = 5'd11;
    localparam logic [4:0] ST_SWP1   = 5'd12;
    localparam logic [4:0] ST_SWP2   = 5'd13;
    localparam logic [4:0] ST_FIN    = 5'd14;
    localparam logic [4:0] ST_FIN1   = 5'd15;
    localparam logic [4:0] ST_FIN2   = 5'd16;
    localparam logic [4:0] ST_PSH1   = 5'd17;
    localparam logic [4:0] ST_PSH2   = 5'd18;
    localparam logic [4:0] ST_EMRD   = 5'd19;
    localparam logic [4:0] ST_EMOUT  = 5'd20;
    localparam logic [4:0] ST_SINGLE = 5'd21;

    logic [4:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                    if (st.eos) state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.op = OP_KCLR;
                if (st.many || st.none) state_next = ST_SINGLE;
                else                    state_next = ST_INIT;
            end
            ST_SINGLE: begin
                if (st.out_free) begin
                    cmd.op     = OP_SINGLE;
                    state_next = ST_IDLE;
                end
            end
            ST_INIT: begin
                if (!st.k_done) begin
                    cmd.op = OP_INIT;
                end else if (st.n_lt2) begin
                    cmd.op     = OP_KCLR;
                    state_next = ST_EMRD;
                end else begin
                    cmd.op     = OP_PUSH0;
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                if (st.sp_zero) begin
                    state_next = ST_EMRD;
                end else begin
                    cmd.op     = OP_POP_RD;
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE: begin
                cmd.op     = OP_RANGE;
                state_next = ST_SWA;
            end
            ST_SWA: begin
                if (st.range_empty) begin
                    state_next = ST_POP;
                end else begin
                    cmd.op     = OP_SW_A;
                    state_next = ST_SWB;
                end
            end
            ST_SWB: begin
                cmd.op     = OP_SW_B;
                state_next = ST_LOOP;
            end
            ST_LOOP: begin
                if (st.loop_done) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.op     = OP_LOOP_RD;
                    state_next = ST_LDI;
                end
            end
            ST_LDI: begin
                cmd.op     = OP_LD_I;
                state_next = ST_CRD;
            end
            ST_CRD: begin
                cmd.op     = OP_C_RD;
                state_next = ST_CEV;
            end
            ST_CEV: begin
                cmd.op = OP_C_STEP;
                if (!st.cmp_done) state_next = ST_CRD;
                else if (st.cmp_lt) state_next = ST_SWP;
                else state_next = ST_LOOP;
            end
            ST_SWP: begin
                cmd.op     = OP_SWP_RD;
                state_next = ST_SWP1;
            end
            ST_SWP1: begin
                cmd.op     = OP_SWP_W1;
                state_next = ST_SWP2;
            end
            ST_SWP2: begin
                cmd.op     = OP_SWP_W2;
                state_next = ST_LOOP;
            end
            ST_FIN: begin
                cmd.op     = OP_FIN_RD;
                state_next = ST_FIN1;
            end
            ST_FIN1: begin
                cmd.op     = OP_FIN_W1;
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                cmd.op     = OP_FIN_W2;
                state_next = ST_PSH1;
            end
            ST_PSH1: begin
                cmd.op     = OP_PUSH_HI;
                state_next = ST_PSH2;
            end
            ST_PSH2: begin
                cmd.op     = OP_PUSH_LO;
                state_next = ST_POP;
            end
            ST_EMRD: begin
                if (st.out_free) begin
                    cmd.op     = OP_EM_RD;
                    state_next = ST_EMOUT;
                end
            end
            ST_EMOUT: begin
                cmd.op     = OP_EM_OUT;
                state_next = st.em_last ? ST_IDLE : ST_EMRD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

`ifndef SYNTHESIS
    // the comparison is never decided while a character is being skipped
    a_done_not_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        st.cmp_skip |-> !st.cmp_done)
        else $error("comparator done while skipping");
    // a swap always completes its two writes before the scan resumes
    a_swap_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWP) |=> (state_reg == ST_SWP1) ##1 (state_reg == ST_SWP2))
        else $error("swap sequence broken");
    // a load is issued only while idle, with s_ready high
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_LOAD) |-> s_ready)
        else $error("load issued outside idle");
`endif

endmodule

>>> hw/rtl/lsc_dp.sv
// Datapath: text, length, order and range stores, comparator, output register.
module lsc_dp (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_addr,
    input  logic           cfg_wdata,
    input  lsc_pkg::in_t   s_data,
    input  logic           m_ready,
    output logic           m_valid,
    output lsc_pkg::out_t  m_data,
    input  lsc_pkg::cmd_t  cmd,
    output lsc_pkg::stat_t st
);
    import lsc_pkg::*;

    // stores
    logic [6:0]  text_mem  [MAX_LINES*MAX_CHARS];
    logic [7:0]  len_mem   [MAX_LINES];
    logic [4:0]  ord_mem   [MAX_LINES];
    logic [11:0] stk_mem   [MAX_LINES];

    logic rev_reg, fold_reg, dir_reg;
    logic [5:0] ll_reg;
    logic [7:0] cp_reg;
    logic [1:0] ovf_reg;
    logic [5:0] k_reg, i_reg, sp_reg;
    logic [4:0] left_reg, right_reg, mid_reg, piv_reg, pl_reg, cl_reg;
    logic [7:0] pa_reg, pb_reg;
    logic [6:0] ta_reg, tb_reg;
    logic [7:0] la_reg, lb_reg;
    logic [4:0] ord_rd0_reg, ord_rd1_reg;
    logic [11:0] stk_rd_reg;
    logic       out_valid_reg;
    out_t       out_reg;

    function automatic logic [6:0] to_lower(input logic [6:0] c);
        to_lower = (c >= 7'h41 && c <= 7'h5A) ? c + 7'd32 : c;
    endfunction

    function automatic logic is_dir(input logic [6:0] c);
        is_dir = (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) ||
                 (c >= 7'h61 && c <= 7'h7A) || c == 7'h20 || (c >= 7'd9 && c <= 7'd13);
    endfunction

    // input decode
    logic load_char, do_close, line_full;
    assign line_full = (ll_reg >= 6'(MAX_LINES));
    assign load_char = (cmd.op == OP_LOAD) && (s_data.opcode == OPC_CHAR) && (s_data.ch != 7'd0);
    assign do_close  = (cmd.op == OP_LOAD) &&
                       ((s_data.opcode == OPC_EOL) ||
                        (s_data.opcode == OPC_EOS && cp_reg != 8'd0));

    // comparator on registered characters
    logic [6:0] ca, cb, fa, fb;
    logic skip_a, skip_b, diff, ltraw;
    assign ca     = (pa_reg < la_reg) ? ta_reg : 7'd0;
    assign cb     = (pb_reg < lb_reg) ? tb_reg : 7'd0;
    assign skip_a = dir_reg && ca != 7'd0 && !is_dir(ca);
    assign skip_b = dir_reg && cb != 7'd0 && !is_dir(cb);
    assign fa     = fold_reg ? to_lower(ca) : ca;
    assign fb     = fold_reg ? to_lower(cb) : cb;
    assign diff   = (fa != fb);
    assign ltraw  = (fa < fb);

    logic [5:0] sum_lr;
    logic [4:0] rng_l, rng_r;
    assign rng_l  = stk_rd_reg[10:6];
    assign rng_r  = stk_rd_reg[4:0];
    assign sum_lr = {1'b0, rng_l} + {1'b0, rng_r};

    logic [5:0] piv_p1;
    assign piv_p1 = {1'b0, piv_reg} + 6'd1;

    always_comb begin
        st.eos         = (s_data.opcode == OPC_EOS);
        st.many        = ovf_reg[1];
        st.none        = (ll_reg == 6'd0);
        st.n_lt2       = (ll_reg < 6'd2);
        st.k_done      = (k_reg == ll_reg);
        st.sp_zero     = (sp_reg == 6'd0);
        st.range_empty = (left_reg >= right_reg);
        st.loop_done   = (i_reg > {1'b0, right_reg});
        st.cmp_skip    = skip_a || skip_b;
        st.cmp_done    = !(skip_a || skip_b) && (diff || fa == 7'd0);
        st.cmp_lt      = diff && (rev_reg ? !ltraw : ltraw);
        st.em_last     = (k_reg == ll_reg - 6'd1);
        st.out_free    = !out_valid_reg || m_ready;
    end

    // order table port addressing
    logic       ord_we, ord_re;
    logic [4:0] ord_wa, ord_wd, ord_ra0, ord_ra1;
    always_comb begin
        ord_we  = 1'b0;
        ord_re  = 1'b0;
        ord_wa  = k_reg[4:0];
        ord_wd  = k_reg[4:0];
        ord_ra0 = left_reg;
        ord_ra1 = mid_reg;
        case (cmd.op)
            OP_INIT:    ord_we = 1'b1;
            OP_RANGE: begin
                ord_re  = 1'b1;
                ord_ra0 = rng_l;
                ord_ra1 = sum_lr[5:1];
            end
            OP_SW_A: begin
                ord_we = 1'b1; ord_wa = left_reg; ord_wd = ord_rd1_reg;
            end
            OP_SW_B: begin
                ord_we = 1'b1; ord_wa = mid_reg; ord_wd = ord_rd0_reg;
            end
            OP_LOOP_RD: begin
                ord_re = 1'b1; ord_ra0 = i_reg[4:0];
            end
            OP_SWP_RD: begin
                ord_re = 1'b1; ord_ra0 = piv_p1[4:0]; ord_ra1 = i_reg[4:0];
            end
            OP_SWP_W1: begin
                ord_we = 1'b1; ord_wa = piv_reg; ord_wd = ord_rd1_reg;
            end
            OP_SWP_W2: begin
                ord_we = 1'b1; ord_wa = i_reg[4:0]; ord_wd = ord_rd0_reg;
            end
            OP_FIN_RD: begin
                ord_re = 1'b1; ord_ra0 = left_reg; ord_ra1 = piv_reg;
            end
            OP_FIN_W1: begin
                ord_we = 1'b1; ord_wa = left_reg; ord_wd = ord_rd1_reg;
            end
            OP_FIN_W2: begin
                ord_we = 1'b1; ord_wa = piv_reg; ord_wd = ord_rd0_reg;
            end
            OP_EM_RD: begin
                ord_re = 1'b1; ord_ra0 = k_reg[4:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ord_we) ord_mem[ord_wa] <= ord_wd;
        if (ord_re) begin
            ord_rd0_reg <= ord_mem[ord_ra0];
            ord_rd1_reg <= ord_mem[ord_ra1];
        end
    end

    // text and length stores
    always_ff @(posedge aclk) begin
        if (load_char && cp_reg < 8'(MAX_CHARS) && !line_full)
            text_mem[{ll_reg[LINE_W-1:0], cp_reg[POS_W-1:0]}] <= s_data.ch;
        if (do_close && !line_full)
            len_mem[ll_reg[LINE_W-1:0]] <= cp_reg;
        if (cmd.op == OP_C_RD) begin
            ta_reg <= text_mem[{cl_reg, pa_reg[POS_W-1:0]}];
            tb_reg <= text_mem[{pl_reg, pb_reg[POS_W-1:0]}];
            la_reg <= len_mem[cl_reg];
            lb_reg <= len_mem[pl_reg];
        end
    end

    // range stack
    logic       push_hi, push_lo;
    assign push_hi = (piv_p1 < {1'b0, right_reg}) && !sp_reg[5];
    assign push_lo = ({1'b0, left_reg} + 6'd1 < {1'b0, piv_reg}) && !sp_reg[5];

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_PUSH0:   stk_mem[0] <= {6'd0, ll_reg - 6'd1};
            OP_PUSH_HI: if (push_hi) stk_mem[sp_reg[4:0]] <= {piv_p1, 1'b0, right_reg};
            OP_PUSH_LO: if (push_lo) stk_mem[sp_reg[4:0]] <= {1'b0, left_reg, 1'b0, piv_reg - 5'd1};
            default: ;
        endcase
        if (cmd.op == OP_POP_RD) stk_rd_reg <= stk_mem[5'(sp_reg - 6'd1)];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rev_reg  <= 1'b0;
            fold_reg <= 1'b0;
            dir_reg  <= 1'b0;
            ll_reg   <= '0;
            cp_reg   <= '0;
            ovf_reg  <= '0;
            sp_reg   <= '0;
            k_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_REVERSE: rev_reg  <= cfg_wdata;
                    CFG_FOLD:    fold_reg <= cfg_wdata;
                    CFG_DIR:     dir_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (load_char) begin
                if (cp_reg >= 8'(MAX_CHARS)) ovf_reg[0] <= 1'b1;
                else                         cp_reg <= cp_reg + 8'd1;
            end
            if (do_close) begin
                if (line_full) ovf_reg[1] <= 1'b1;
                else           ll_reg <= ll_reg + 6'd1;
                cp_reg <= '0;
            end
            if (cmd.op == OP_SINGLE || cmd.op == OP_EM_OUT) out_valid_reg <= 1'b1;
            else if (m_ready)                               out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_KCLR:    k_reg <= '0;
                OP_INIT:    k_reg <= k_reg + 6'd1;
                OP_PUSH0: begin
                    sp_reg <= 6'd1;
                    k_reg  <= '0;
                end
                OP_POP_RD:  sp_reg <= sp_reg - 6'd1;
                OP_PUSH_HI: if (push_hi) sp_reg <= sp_reg + 6'd1;
                OP_PUSH_LO: if (push_lo) sp_reg <= sp_reg + 6'd1;
                OP_SINGLE: begin
                    ll_reg  <= '0;
                    cp_reg  <= '0;
                    ovf_reg <= '0;
                end
                OP_EM_OUT: begin
                    k_reg <= k_reg + 6'd1;
                    if (st.em_last) begin
                        ll_reg  <= '0;
                        cp_reg  <= '0;
                        ovf_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // partition and comparison registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_RANGE: begin
                left_reg  <= rng_l;
                right_reg <= rng_r;
                mid_reg   <= sum_lr[5:1];
            end
            OP_SW_A:   pl_reg <= ord_rd1_reg;
            OP_SW_B: begin
                piv_reg <= left_reg;
                i_reg   <= {1'b0, left_reg} + 6'd1;
            end
            OP_LD_I: begin
                cl_reg <= ord_rd0_reg;
                pa_reg <= '0;
                pb_reg <= '0;
            end
            OP_C_STEP: begin
                if (skip_a || skip_b) begin
                    if (skip_a) pa_reg <= pa_reg + 8'd1;
                    if (skip_b) pb_reg <= pb_reg + 8'd1;
                end else if (!diff && fa != 7'd0) begin
                    pa_reg <= pa_reg + 8'd1;
                    pb_reg <= pb_reg + 8'd1;
                end else if (!st.cmp_lt) begin
                    i_reg <= i_reg + 6'd1;
                end
            end
            OP_SWP_RD: piv_reg <= piv_p1[4:0];
            OP_SWP_W2: i_reg <= i_reg + 6'd1;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_SINGLE: begin
                out_reg.line_index <= '0;
                out_reg.last       <= 1'b1;
                out_reg.status     <= ovf_reg[1] ? STS_MANY : STS_NONE;
            end
            OP_EM_OUT: begin
                out_reg.line_index <= {1'b0, ord_rd0_reg};
                out_reg.last       <= st.em_last;
                out_reg.status     <= ovf_reg[0] ? STS_TRUNC : STS_OK;
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_ll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ll_reg <= 6'(MAX_LINES))
        else $error("line count out of range");
    a_cp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cp_reg <= 8'(MAX_CHARS))
        else $error("char position out of range");
    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= 6'(MAX_LINES))
        else $error("range stack overrun");
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == STS_MANY || m_data.status == STS_NONE))
        |-> m_data.last)
        else $error("error result not marked last");
`endif

endmodule

>>> hw/rtl/line_sorter_with_collation_modes_top.sv
// Top level of the line sorter: controller plus datapath.
//
// Input channel s_valid/s_ready/s_data carries one transaction per cycle
// while s_ready is high: append a character, end the current line, or end
// the set. End of set starts the sort, during which s_ready stays low.
// The sort is a quicksort with middle pivot, Lomuto partition and a range
// stack held in memory. Each character step of a line comparison is a
// registered text read, then an evaluate step; a swap is a read and two
// writes, a range pop a stack read and a range load. Total sort time
// therefore depends on the data.
// Results leave on m_valid/m_ready/m_data, one per sorted rank; a stalled
// receiver holds the output register and the emitter waits. The next run's
// characters are accepted while the final result is still waiting.
// Configuration (cfg_we/cfg_addr/cfg_wdata) must be written only while
// idle; the block itself does not enforce it.
// Reset (aresetn low, synchronous) clears counters, flags, configuration and
// the output valid; the stores need no clearing pass.
module line_sorter_with_collation_modes_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic          cfg_wdata,
    input  logic          s_valid,
    output logic          s_ready,
    input  lsc_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lsc_pkg::out_t m_data
);
    import lsc_pkg::*;

    cmd_t  cmd;
    stat_t st;

    lsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    lsc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
